>>> design/plt_pkg.sv
// Shared constants and types of the peer liveness table.
// Used by plt_unit, peer_liveness_table and the testbench; depends on nothing else.
package plt_pkg;

   localparam int NUM_PEERS   = 2;
   localparam int MAX_ENTRIES = 4;
   localparam int ENTRY_W     = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
   localparam int CNT_W       = $clog2(NUM_PEERS + 1);

   localparam int MAC_W   = 48;
   localparam int SEQ_W   = 16;
   localparam int TIME_W  = 32;
   localparam int PIDX_W  = 3;
   localparam int REQ_W   = 104;
   localparam int RSP_W   = 96;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      OP_FRAME = 2'd0,
      OP_TICK  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] REG_PEER_ENABLE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT     = 3'd5;

   localparam logic [MAX_ENTRIES-1:0] ENABLE_RESET  = 4'd3;
   localparam logic [TIME_W-1:0]      TIMEOUT_RESET = 32'd3000;

   typedef struct packed {
      logic              age_mode;
      logic [MAC_W-1:0]  entry_mac;
      logic [MAC_W-1:0]  frame_mac;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] seen_ms;
      logic [TIME_W-1:0] timeout_ms;
   } unit_req_type;

endpackage

>>> design/plt_unit.sv
// Shared compare unit of the peer liveness table: MAC match or age check.
// Depends on plt_pkg.
module plt_unit (
   input  plt_pkg::unit_req_type unit_req,
   output logic                  hit
);

   logic [plt_pkg::TIME_W-1:0] age;

   assign age = unit_req.now_ms - unit_req.seen_ms;
   assign hit = unit_req.age_mode ? (age > unit_req.timeout_ms)
                                  : (unit_req.entry_mac == unit_req.frame_mac);

endmodule

>>> design/peer_liveness_table.sv
// Top level of the peer liveness table: configuration, sequencer and entries.
// Depends on plt_pkg and plt_unit.
//
// One request beat is taken at a time. A frame visits the entries one per cycle
// through a single shared compare unit and stops at the first enabled match, so
// it visits from 1 to NUM_PEERS entries. A tick visits every entry. A query or
// an unknown op skips the scan and goes to the finish state. The response beat
// is held in an output register, so the next request beat is taken while a
// response still waits; the sequencer stalls only when a new response is ready
// and the old one has not been taken. Configuration beats are always accepted.
module peer_liveness_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // mac[47:0], sequence_req[63:48], now_ms[95:64], peer_index[98:96], zeros
   input  logic [plt_pkg::REQ_W-1:0]       req_tdata,
   // op[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // matched[0], match_index[2:1], online_mask[6:3], online_count[9:7],
   // query_status[10], info_online[11], info_last_seen_ms[43:12],
   // info_packet_count[75:44], info_last_sequence[91:76], zeros
   output logic [plt_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [plt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [plt_pkg::MAC_W-1:0]       csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [plt_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic matched_ff, matched_in;
   logic [1:0] match_idx_ff, match_idx_in;

   plt_pkg::op_type op_ff, op_in;
   logic [plt_pkg::MAC_W-1:0]  mac_ff, mac_in;
   logic [plt_pkg::SEQ_W-1:0]  seq_ff, seq_in;
   logic [plt_pkg::TIME_W-1:0] now_ff, now_in;
   logic qbad_ff, qbad_in;

   logic [plt_pkg::MAC_W-1:0] peer_mac_ff [plt_pkg::MAX_ENTRIES];
   logic [plt_pkg::MAC_W-1:0] peer_mac_in [plt_pkg::MAX_ENTRIES];
   logic [plt_pkg::MAX_ENTRIES-1:0] enable_ff, enable_in;
   logic [plt_pkg::TIME_W-1:0] timeout_ff, timeout_in;

   logic [plt_pkg::TIME_W-1:0] seen_time_ff [plt_pkg::NUM_PEERS];
   logic [plt_pkg::TIME_W-1:0] seen_time_in [plt_pkg::NUM_PEERS];
   logic [plt_pkg::TIME_W-1:0] frame_count_ff [plt_pkg::NUM_PEERS];
   logic [plt_pkg::TIME_W-1:0] frame_count_in [plt_pkg::NUM_PEERS];
   logic [plt_pkg::SEQ_W-1:0] last_seq_ff [plt_pkg::NUM_PEERS];
   logic [plt_pkg::SEQ_W-1:0] last_seq_in [plt_pkg::NUM_PEERS];
   logic [plt_pkg::NUM_PEERS-1:0] alive_ff, alive_in;

   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic [plt_pkg::RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic [plt_pkg::ENTRY_W-1:0] entry;
   logic [1:0] slot;
   plt_pkg::unit_req_type unit_req;
   logic unit_hit;
   logic last_entry;
   logic out_free;
   logic [plt_pkg::MAX_ENTRIES-1:0] mask;
   logic [2:0] count;

   assign entry      = cnt_ff[plt_pkg::ENTRY_W-1:0];
   assign slot       = 2'(entry);
   assign last_entry = (cnt_ff == plt_pkg::CNT_W'(plt_pkg::NUM_PEERS - 1));
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_comb begin
      unit_req.age_mode   = (op_ff == plt_pkg::OP_TICK);
      unit_req.entry_mac  = peer_mac_ff[slot];
      unit_req.frame_mac  = mac_ff;
      unit_req.now_ms     = now_ff;
      unit_req.seen_ms    = seen_time_ff[entry];
      unit_req.timeout_ms = timeout_ff;
   end

   plt_unit u_unit (
      .unit_req (unit_req),
      .hit      (unit_hit)
   );

   always_comb begin
      mask  = '0;
      count = '0;
      for (int i = 0; i < plt_pkg::NUM_PEERS; i++) begin
         mask[i] = alive_ff[i];
         count   = count + {2'd0, alive_ff[i]};
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      matched_in    = matched_ff;
      match_idx_in  = match_idx_ff;
      op_in         = op_ff;
      mac_in        = mac_ff;
      seq_in        = seq_ff;
      now_in        = now_ff;
      qbad_in       = qbad_ff;
      peer_mac_in   = peer_mac_ff;
      enable_in     = enable_ff;
      timeout_in    = timeout_ff;
      seen_time_in  = seen_time_ff;
      frame_count_in = frame_count_ff;
      last_seq_in   = last_seq_ff;
      alive_in      = alive_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      if (csr_valid) begin
         if (csr_index < plt_pkg::REG_PEER_ENABLE) begin
            peer_mac_in[csr_index[1:0]] = csr_data;
         end else if (csr_index == plt_pkg::REG_PEER_ENABLE) begin
            enable_in = csr_data[plt_pkg::MAX_ENTRIES-1:0];
         end else if (csr_index == plt_pkg::REG_TIMEOUT) begin
            timeout_in = csr_data[plt_pkg::TIME_W-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in      = plt_pkg::op_type'(req_tuser);
               mac_in     = req_tdata[47:0];
               seq_in     = req_tdata[63:48];
               now_in     = req_tdata[95:64];
               qbad_in    = (req_tdata[98:96] >= plt_pkg::PIDX_W'(plt_pkg::NUM_PEERS));
               matched_in = 1'b0;
               match_idx_in = 2'd0;
               if (plt_pkg::op_type'(req_tuser) == plt_pkg::OP_FRAME ||
                   plt_pkg::op_type'(req_tuser) == plt_pkg::OP_TICK) begin
                  cnt_in   = '0;
                  state_in = ST_SCAN;
               end else begin
                  cnt_in   = plt_pkg::CNT_W'(req_tdata[98:96]);
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (op_ff == plt_pkg::OP_FRAME) begin
               if (enable_ff[slot] && unit_hit) begin
                  seen_time_in[entry]   = now_ff;
                  frame_count_in[entry] = frame_count_ff[entry] + 32'd1;
                  last_seq_in[entry]    = seq_ff;
                  alive_in[entry]       = 1'b1;
                  matched_in            = 1'b1;
                  match_idx_in          = 2'(cnt_ff);
                  state_in              = ST_FINISH;
               end
            end else begin
               if (enable_ff[slot] && alive_ff[entry] &&
                   seen_time_ff[entry] != '0 && unit_hit) begin
                  alive_in[entry] = 1'b0;
               end
            end
            if (last_entry) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + plt_pkg::CNT_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_tvalid_in       = 1'b1;
               rsp_tdata_in        = '0;
               rsp_tdata_in[0]     = matched_ff;
               rsp_tdata_in[2:1]   = match_idx_ff;
               rsp_tdata_in[6:3]   = mask;
               rsp_tdata_in[9:7]   = count;
               if (op_ff == plt_pkg::OP_QUERY) begin
                  if (qbad_ff) begin
                     rsp_tdata_in[10] = 1'b1;
                  end else begin
                     rsp_tdata_in[11]    = alive_ff[entry];
                     rsp_tdata_in[43:12] = seen_time_ff[entry];
                     rsp_tdata_in[75:44] = frame_count_ff[entry];
                     rsp_tdata_in[91:76] = last_seq_ff[entry];
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      mac_ff       <= mac_in;
      seq_ff       <= seq_in;
      now_ff       <= now_in;
      qbad_ff      <= qbad_in;
      rsp_tdata_ff <= rsp_tdata_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         matched_ff    <= 1'b0;
         match_idx_ff  <= 2'd0;
         rsp_tvalid_ff <= 1'b0;
         enable_ff     <= plt_pkg::ENABLE_RESET;
         timeout_ff    <= plt_pkg::TIMEOUT_RESET;
         alive_ff      <= '0;
         for (int i = 0; i < plt_pkg::MAX_ENTRIES; i++) begin
            peer_mac_ff[i] <= '0;
         end
         for (int i = 0; i < plt_pkg::NUM_PEERS; i++) begin
            seen_time_ff[i]   <= '0;
            frame_count_ff[i] <= '0;
            last_seq_ff[i]    <= '0;
         end
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         matched_ff     <= matched_in;
         match_idx_ff   <= match_idx_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
         enable_ff      <= enable_in;
         timeout_ff     <= timeout_in;
         alive_ff       <= alive_in;
         peer_mac_ff    <= peer_mac_in;
         seen_time_ff   <= seen_time_in;
         frame_count_ff <= frame_count_in;
         last_seq_ff    <= last_seq_in;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a beat is still in work");

   a_count_matches_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($countones(rsp_tdata[6:3]) == int'(rsp_tdata[9:7])))
      else $error("online count differs from online mask");

   a_bad_query_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[10]) |-> (rsp_tdata[91:11] == '0))
      else $error("invalid query carries record fields");

   a_no_match_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[2:1] == 2'd0))
      else $error("match index set without a match");

endmodule

>>> tb/plt_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the peer liveness table: a table predictor and a queue of predicted responses.
// Depends on plt_pkg for the widths, the op codes and the register indexes.
package plt_tb_pkg;

   import plt_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_PEER_MAC_BASE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PEER_MAC_LAST = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI     = 3'd7;

   typedef struct {
      bit          matched;
      bit [1:0]    match_index;
      bit [3:0]    online_mask;
      bit [2:0]    online_count;
      bit          query_status;
      bit          info_online;
      bit [31:0]   info_last_seen_ms;
      bit [31:0]   info_packet_count;
      bit [15:0]   info_seq;
   } peer_report_type;

   class liveness_scoreboard;
      bit [47:0]    peer_mac [MAX_ENTRIES];
      bit [3:0]     peer_enable;
      bit [31:0]    timeout_ms;
      bit [31:0]    seen_ms [MAX_ENTRIES];
      bit [31:0]    frame_total [MAX_ENTRIES];
      bit [15:0]    recent_seq [MAX_ENTRIES];
      bit           online [MAX_ENTRIES];
      peer_report_type predicted_reports [$];
      int           errors;

      function new();
         int i;
         for (i = 0; i < MAX_ENTRIES; i++) begin
            peer_mac[i]    = '0;
            seen_ms[i]     = '0;
            frame_total[i] = '0;
            recent_seq[i]  = '0;
            online[i]      = 1'b0;
         end
         peer_enable = ENABLE_RESET;
         timeout_ms  = TIMEOUT_RESET;
         errors      = 0;
      endfunction

      function int pending();
         return predicted_reports.size();
      endfunction

      function void note_register(logic [CSR_IDX_W-1:0] index, logic [MAC_W-1:0] data);
         if (index <= REG_PEER_MAC_LAST) begin
            peer_mac[index[1:0]] = data;
         end else if (index == REG_PEER_ENABLE) begin
            peer_enable = data[3:0];
         end else if (index == REG_TIMEOUT) begin
            timeout_ms = data[31:0];
         end
      endfunction

      function void note_request(op_type op, bit [47:0] mac, bit [15:0] sequence_req,
                                 bit [31:0] now_ms, bit [2:0] peer_index);
         peer_report_type r;
         bit [31:0]    age;
         bit           found;
         int           i;
         r     = '{default: 0};
         found = 1'b0;
         case (op)
            OP_FRAME: begin
               for (i = 0; i < NUM_PEERS; i++) begin
                  if (!found && peer_enable[i] && peer_mac[i] == mac) begin
                     found          = 1'b1;
                     seen_ms[i]     = now_ms;
                     frame_total[i] = frame_total[i] + 32'd1;
                     recent_seq[i]  = sequence_req;
                     online[i]      = 1'b1;
                     r.matched      = 1'b1;
                     r.match_index  = 2'(i);
                  end
               end
            end
            OP_TICK: begin
               for (i = 0; i < NUM_PEERS; i++) begin
                  age = now_ms - seen_ms[i];
                  if (peer_enable[i] && online[i] && seen_ms[i] != 0 && age > timeout_ms)
                     online[i] = 1'b0;
               end
            end
            OP_QUERY: begin
               if (peer_index >= NUM_PEERS) begin
                  r.query_status = 1'b1;
               end else begin
                  r.info_online       = online[peer_index[1:0]];
                  r.info_last_seen_ms = seen_ms[peer_index[1:0]];
                  r.info_packet_count = frame_total[peer_index[1:0]];
                  r.info_seq          = recent_seq[peer_index[1:0]];
               end
            end
            default: ;
         endcase
         for (i = 0; i < NUM_PEERS; i++) begin
            if (online[i]) begin
               r.online_mask[i] = 1'b1;
               r.online_count   = r.online_count + 3'd1;
            end
         end
         predicted_reports.push_back(r);
      endfunction

      function void compare_field(string name, longint unsigned expv, longint unsigned actv);
         if (expv != actv) begin
            $error("%s: expected %0h, got %0h", name, expv, actv);
            errors++;
         end
      endfunction

      function void check_response(logic [RSP_W-1:0] d);
         peer_report_type e;
         if (predicted_reports.size() == 0) begin
            $error("response beat %0h arrived with no request outstanding", d);
            errors++;
         end else begin
            e = predicted_reports.pop_front();
            compare_field("matched", e.matched, d[0]);
            compare_field("match_index", e.match_index, d[2:1]);
            compare_field("online_mask", e.online_mask, d[6:3]);
            compare_field("online_count", e.online_count, d[9:7]);
            compare_field("query_status", e.query_status, d[10]);
            compare_field("info_online", e.info_online, d[11]);
            compare_field("info_last_seen_ms", e.info_last_seen_ms, d[43:12]);
            compare_field("info_packet_count", e.info_packet_count, d[75:44]);
            compare_field("info_last_sequence", e.info_seq, d[91:76]);
         end
      endfunction
   endclass

endpackage

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top-level testbench of peer_liveness_table: directed and random frame, tick and query beats
// with random stalls on both sides. Depends on plt_pkg, plt_tb_pkg and the RTL.
module tb;

   import plt_pkg::*;
   import plt_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;
   logic [1:0]           req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [MAC_W-1:0]     csr_data;

   liveness_scoreboard sb;
   bit                 idle_on;
   bit                 long_hold_req;
   int                 hold_left;
   int                 quiet_cycles;
   bit [47:0]          phase_mac [MAX_ENTRIES];
   bit [3:0]           phase_enable;
   bit [31:0]          phase_timeout;
   bit [31:0]          wall_ms;

   peer_liveness_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.note_register(csr_index, csr_data);
         if (req_tvalid && req_tready)
            sb.note_request(op_type'(req_tuser), req_tdata[47:0], req_tdata[63:48],
                            req_tdata[95:64], req_tdata[98:96]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata);
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = 299;
            rsp_tready    <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            hold_left  = $urandom_range(0, 18);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic bit [47:0] rand_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic send_event(input op_type op, input bit [47:0] mac, input bit [15:0] seq,
                             input bit [31:0] now, input bit [2:0] pidx);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'd0, pidx, now, seq, mac};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index, input logic [47:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_table_config(input bit with_unused);
      int i;
      for (i = 0; i < MAX_ENTRIES; i++)
         write_register(REG_PEER_MAC_BASE + 3'(i), phase_mac[i]);
      write_register(REG_PEER_ENABLE, {44'd0, phase_enable});
      write_register(REG_TIMEOUT, {16'd0, phase_timeout});
      if (with_unused) begin
         write_register(REG_UNUSED_LO, rand_mac());
         write_register(REG_UNUSED_HI, rand_mac());
      end
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_random_phase(input int count);
      int        k;
      int        pick;
      op_type    op;
      bit [47:0] mac;
      bit [31:0] now;
      bit [2:0]  pidx;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            op = OP_FRAME;
         else if (pick < 75)
            op = OP_TICK;
         else if (pick < 95)
            op = OP_QUERY;
         else
            op = OP_NONE;
         mac  = ($urandom_range(0, 4) != 0) ? phase_mac[2'($urandom_range(0, 3))] : rand_mac();
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            now = '0;
         end else if (pick < 10) begin
            now = $urandom;
         end else begin
            wall_ms = wall_ms + $urandom_range(0, 400);
            now     = wall_ms;
         end
         pidx = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, NUM_PEERS - 1))
                                           : 3'($urandom_range(0, 7));
         send_event(op, mac, 16'($urandom), now, pidx);
      end
   endtask

   initial begin
      int        ph;
      int        i;
      bit [47:0] stray_mac;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      idle_on       = 1'b1;
      long_hold_req = 1'b0;
      hold_left     = 0;
      quiet_cycles  = 0;
      wall_ms       = 32'd5000;
      sb            = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: both entries enabled with MAC zero, timeout 3000.
      send_event(OP_QUERY, '0, '0, '0, 3'd0);
      send_event(OP_FRAME, '0, 16'd7, 32'd5, 3'd0);
      send_event(OP_QUERY, '0, '0, '0, 3'd0);
      send_event(OP_TICK, '0, '0, 32'd10000, 3'd0);
      send_event(OP_QUERY, '0, '0, '0, 3'd0);
      send_event(OP_NONE, rand_mac(), 16'($urandom), $urandom, 3'd0);
      drain();

      phase_mac[0]  = 48'hFFFF_FFFF_FFFF;
      phase_mac[1]  = 48'h0000_0000_0001;
      phase_mac[2]  = 48'h0A0B_0C0D_0E0F;
      phase_mac[3]  = rand_mac();
      phase_enable  = 4'hF;
      phase_timeout = 32'd100;
      load_table_config(1'b1);
      do stray_mac = rand_mac(); while (stray_mac == phase_mac[0] || stray_mac == phase_mac[1]);

      send_event(OP_QUERY, '0, '0, '0, 3'(NUM_PEERS));
      send_event(OP_QUERY, '0, '0, '0, 3'd7);
      send_event(OP_NONE, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 3'd7);
      // A frame at time zero keeps the entry online through any tick.
      send_event(OP_FRAME, phase_mac[0], 16'hFFFF, 32'd0, 3'd0);
      send_event(OP_TICK, '0, '0, 32'hFFFF_FFFF, 3'd0);
      send_event(OP_QUERY, '0, '0, '0, 3'd0);
      send_event(OP_FRAME, phase_mac[1], 16'd0, 32'd1000, 3'd0);
      send_event(OP_FRAME, phase_mac[2], 16'd3, 32'd1000, 3'd0);
      send_event(OP_FRAME, stray_mac, 16'd4, 32'd1000, 3'd0);
      send_event(OP_TICK, '0, '0, 32'd1100, 3'd0);
      send_event(OP_TICK, '0, '0, 32'd1101, 3'd0);
      // The age is taken modulo 2^32, so a wrapped clock stays within the timeout.
      send_event(OP_FRAME, phase_mac[0], 16'd1, 32'hFFFF_FFF0, 3'd0);
      send_event(OP_TICK, '0, '0, 32'd50, 3'd0);
      send_event(OP_TICK, '0, '0, 32'd200, 3'd0);
      send_event(OP_QUERY, '0, '0, '0, 3'd0);
      send_event(OP_QUERY, '0, '0, '0, 3'd1);
      drain();

      for (ph = 1; ph <= 6; ph++) begin
         for (i = 0; i < MAX_ENTRIES; i++)
            phase_mac[i] = rand_mac();
         if ($urandom_range(0, 3) == 0)
            phase_mac[1] = phase_mac[0];
         case (ph)
            1:       phase_enable = 4'hF;
            2:       phase_enable = 4'h0;
            default: phase_enable = 4'($urandom_range(0, 15));
         endcase
         case (ph)
            3:       phase_timeout = 32'd0;
            4:       phase_timeout = 32'hFFFF_FFFF;
            default: phase_timeout = $urandom_range(0, 600);
         endcase
         load_table_config(ph[0]);
         if (ph == 1)
            long_hold_req = 1'b1;
         if (ph == 6)
            idle_on = 1'b0;
         run_random_phase((ph == 2) ? 100 : 180);
         drain();
      end

      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
